// ===== hdl/imhq_pkg.sv =====
package imhq_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_CHANGE = 2'd1,
    CMD_DELMIN = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_ACT,
    S_FILL,
    S_LOAD,
    S_RDA,
    S_RDB,
    S_CMP,
    S_PUT,
    S_DONE
  } state_e;

  // datapath operations requested by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_POS_RD,
    OP_ACTION,
    OP_FILL,
    OP_LOAD,
    OP_RD_A,
    OP_RD_B,
    OP_COMPARE,
    OP_PUT
  } op_e;

  typedef struct packed {
    logic done;   // command finished, result ready
    logic fill;   // taken entry is read out next
    logic walk;   // sift starts right away
    logic stop;   // sift ended, write the moving entry home
    logic more;   // keep walking
  } dp_status_t;

endpackage

// ===== hdl/imhq_ctrl.sv =====
module imhq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output imhq_pkg::op_e         op_o,
  input  imhq_pkg::dp_status_t  st_i
);
  import imhq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_o        = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_CAPTURE;
          state_d = S_POS;
        end
      end
      S_POS: begin
        op_o    = OP_POS_RD;
        state_d = S_ACT;
      end
      S_ACT: begin
        op_o = OP_ACTION;
        if (st_i.done) state_d = S_DONE;
        else if (st_i.walk) state_d = S_RDA;
        else if (st_i.fill) state_d = S_FILL;
        else state_d = S_LOAD;
      end
      S_FILL: begin
        op_o = OP_FILL;
        if (st_i.done) state_d = S_DONE;
        else state_d = S_LOAD;
      end
      S_LOAD: begin
        op_o    = OP_LOAD;
        state_d = S_RDA;
      end
      S_RDA: begin
        op_o    = OP_RD_A;
        state_d = st_i.stop ? S_PUT : S_RDB;
      end
      S_RDB: begin
        op_o    = OP_RD_B;
        state_d = S_CMP;
      end
      S_CMP: begin
        op_o    = OP_COMPARE;
        state_d = st_i.more ? S_RDA : S_PUT;
      end
      S_PUT: begin
        op_o    = OP_PUT;
        state_d = S_DONE;
      end
      S_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready during result");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_ready_i) |=> in_ready_o) else $error("no return");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_POS) else $error("bad start");
`endif
endmodule

// ===== hdl/imhq_dp.sv =====
module imhq_dp #(
  parameter int CAPACITY = 128,
  parameter int ID_SPACE = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imhq_pkg::op_e         op_i,
  output imhq_pkg::dp_status_t  st_o,
  input  logic [1:0]            cmd_i,
  input  logic [7:0]            item_id_i,
  input  logic signed [31:0]    item_key_i,
  input  logic [31:0]           item_data_i,
  output logic [2:0]            status_o,
  output logic [7:0]            out_id_o,
  output logic signed [31:0]    out_key_o,
  output logic [31:0]           out_data_o
);
  import imhq_pkg::*;

  localparam int SW = $clog2(CAPACITY + 1);
  localparam int IW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
  localparam int EW = 72;

  // slot entry: {key, id, data}
  logic [EW-1:0] heap_mem [1:CAPACITY];
  logic [SW-1:0] pos_mem  [ID_SPACE];
  logic [ID_SPACE-1:0] present_q;

  logic [SW-1:0] count_q;
  cmd_e          cmd_q;
  logic [7:0]    id_q;
  logic [31:0]   key_q, data_q;
  status_e       status_q;
  logic [7:0]    oid_q;
  logic [31:0]   okey_q, odata_q;
  logic [SW-1:0] p_q;
  logic [EW-1:0] cur_q;         // entry being walked, written home at the end
  logic [EW-1:0] a_q;           // parent or left child
  logic [SW-1:0] pos_rd_q;
  logic          up_q;
  logic          try_down_q;    // remove walks down if the first up step fails

  logic          id_ok;
  logic [IW-1:0] idx;
  logic          have;
  logic          full;
  logic [SW:0]   l_w, r_w, cnt_w;

  assign id_ok = ({24'd0, id_q} < 32'(ID_SPACE));
  assign idx   = IW'(id_q);
  assign have  = id_ok && present_q[idx];
  assign full  = (count_q >= SW'(CAPACITY));
  assign l_w   = {p_q, 1'b0};
  assign r_w   = {p_q, 1'b1};
  assign cnt_w = {1'b0, count_q};

  function automatic logic kless(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // memory write port (one per cycle) and registered read
  logic          hw_en;
  logic [SW-1:0] hw_addr;
  logic [EW-1:0] hw_data;
  logic [SW-1:0] hr_addr;
  logic [EW-1:0] hr_q;
  logic          pw_en;
  logic [IW-1:0] pw_addr;
  logic [SW-1:0] pw_data;

  always_ff @(posedge clk_i) begin
    if (hw_en) heap_mem[hw_addr] <= hw_data;
    hr_q <= heap_mem[hr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) pos_mem[pw_addr] <= pw_data;
    pos_rd_q <= pos_mem[idx];
  end

  // walk step: a_q holds parent or left child, hr_q the right child
  logic [SW:0]   tgt;
  logic          tgt_left;
  logic          go;
  logic [EW-1:0] child;
  logic [EW-1:0] mover;
  always_comb begin
    hw_en = 1'b0; hw_addr = p_q; hw_data = cur_q;
    pw_en = 1'b0; pw_addr = IW'(cur_q[39:32]); pw_data = p_q;
    hr_addr = p_q;
    st_o = '0;
    // equal keys take the right child
    tgt_left = (r_w > cnt_w) || kless(a_q[71:40], hr_q[71:40]);
    child    = tgt_left ? a_q : hr_q;
    go       = up_q ? kless(cur_q[71:40], a_q[71:40]) : kless(child[71:40], cur_q[71:40]);
    tgt      = up_q ? {1'b0, p_q >> 1} : (tgt_left ? l_w : r_w);
    mover    = up_q ? a_q : child;
    case (op_i)
      OP_ACTION: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (full || !id_ok || have) st_o.done = 1'b1;
            else st_o.walk = 1'b1;
          end
          CMD_CHANGE: begin
            if (!have) st_o.done = 1'b1;
            hr_addr = pos_rd_q;
          end
          CMD_DELMIN: begin
            if (count_q == '0) st_o.done = 1'b1;
            else st_o.fill = 1'b1;
            hr_addr = SW'(1);
          end
          default: begin
            if (!have) st_o.done = 1'b1;
            else st_o.fill = 1'b1;
            hr_addr = pos_rd_q;
          end
        endcase
      end
      OP_FILL: begin
        hr_addr = count_q;
        if (p_q == count_q) st_o.done = 1'b1;
      end
      OP_RD_A: begin
        if (up_q) begin
          if (p_q <= SW'(1)) st_o.stop = 1'b1;
          hr_addr = p_q >> 1;
        end else begin
          if (l_w > cnt_w) st_o.stop = 1'b1;
          hr_addr = l_w[SW-1:0];
        end
      end
      OP_RD_B: hr_addr = r_w[SW-1:0];
      OP_COMPARE: begin
        // the displaced entry drops into p, cur stays in a register
        if (go) begin
          hw_en = 1'b1; hw_data = mover;
          pw_en = 1'b1; pw_addr = IW'(mover[39:32]);
        end
        st_o.more = go || (up_q && try_down_q);
      end
      OP_PUT: begin
        hw_en = 1'b1;
        pw_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      count_q   <= '0;
    end else begin
      case (op_i)
        OP_ACTION: begin
          if (cmd_q == CMD_INSERT && st_o.walk) begin
            present_q[idx] <= 1'b1;
            count_q <= count_q + 1'b1;
          end
          if (cmd_q == CMD_REMOVE && have) present_q[idx] <= 1'b0;
        end
        OP_FILL: begin
          if (cmd_q == CMD_DELMIN) present_q[IW'(hr_q[39:32])] <= 1'b0;
          count_q <= count_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_CAPTURE: begin
        cmd_q <= cmd_e'(cmd_i); id_q <= item_id_i;
        key_q <= item_key_i; data_q <= item_data_i;
        status_q <= ST_OK; oid_q <= '0; okey_q <= '0; odata_q <= '0;
      end
      OP_ACTION: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (full) status_q <= ST_FULL;
            else if (!id_ok) status_q <= ST_NOTFOUND;
            else if (have) status_q <= ST_DUP;
            p_q <= count_q + 1'b1;
            cur_q <= {key_q, id_q, data_q};
            up_q <= 1'b1;
            try_down_q <= 1'b0;
          end
          CMD_CHANGE: begin
            if (!have) status_q <= ST_NOTFOUND;
            p_q <= pos_rd_q;
          end
          CMD_DELMIN: begin
            if (count_q == '0) status_q <= ST_EMPTY;
            p_q <= SW'(1);
          end
          default: begin
            if (!have) status_q <= ST_NOTFOUND;
            p_q <= pos_rd_q;
          end
        endcase
      end
      OP_FILL: begin
        // hr_q holds the taken entry
        if (cmd_q == CMD_DELMIN) oid_q <= hr_q[39:32];
        okey_q  <= hr_q[71:40];
        odata_q <= hr_q[31:0];
      end
      OP_LOAD: begin
        // change key: hr_q is the old entry at p; others: the last entry
        if (cmd_q == CMD_CHANGE) begin
          cur_q      <= {key_q, hr_q[39:0]};
          up_q       <= kless(key_q, hr_q[71:40]);
          try_down_q <= 1'b0;
        end else begin
          cur_q      <= hr_q;
          up_q       <= (cmd_q == CMD_REMOVE) && (p_q > SW'(1));
          try_down_q <= (cmd_q == CMD_REMOVE) && (p_q > SW'(1));
        end
      end
      OP_RD_B: a_q <= hr_q;
      OP_COMPARE: begin
        if (go) begin
          p_q        <= tgt[SW-1:0];
          try_down_q <= 1'b0;
        end else if (up_q && try_down_q) begin
          up_q       <= 1'b0;
          try_down_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_id_o   = oid_q;
  assign out_key_o  = okey_q;
  assign out_data_o = odata_q;
  assign status_o   = status_q;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SW'(CAPACITY)) else $error("count over capacity");
  a_walk_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_COMPARE |-> p_q != '0) else $error("walk at slot zero");
  a_present_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_FILL) |-> count_q != '0) else $error("fill on empty");
  a_put_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_PUT) |-> (p_q != '0 && p_q <= count_q)) else $error("put out of heap");
`endif
endmodule

// ===== hdl/indexed_min_heap_queue.sv =====
// Indexed binary min-heap of up to CAPACITY (id, key, data) words with an
// id-indexed position table, so an entry can be re-keyed or removed by id.
// One command word at a time: insert, change key, delete minimum, remove by
// id; one result word per command with a status. The heap slots sit in a
// memory with one registered read and one write per cycle, so each level
// that a sift compares takes two reads, then a compare and write; a sift
// ends by writing the moving entry home, after a last bounds check where
// it runs out of children or reaches the root. The next word is accepted
// the cycle after the result word is taken. No clearing pass runs after
// reset; only the per-id present bits and the entry count are cleared.
module indexed_min_heap_queue #(
  parameter int CAPACITY = 128,
  parameter int ID_SPACE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         item_id_i,
  input  logic signed [31:0] item_key_i,
  input  logic [31:0]        item_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [7:0]         out_id_o,
  output logic signed [31:0] out_key_o,
  output logic [31:0]        out_data_o
);
  import imhq_pkg::*;

  op_e        op;
  dp_status_t st;

  imhq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .op_o(op), .st_i(st)
  );

  imhq_dp #(.CAPACITY(CAPACITY), .ID_SPACE(ID_SPACE)) u_dp (
    .clk_i, .rst_ni, .op_i(op), .st_o(st),
    .cmd_i, .item_id_i, .item_key_i, .item_data_i,
    .status_o, .out_id_o, .out_key_o, .out_data_o
  );
endmodule

// ===== tb/tb_indexed_min_heap_queue.sv =====
module tb_indexed_min_heap_queue;
  import imhq_pkg::*;

  localparam int CAP = 128;
  localparam int IDS = 256;

  typedef struct packed {
    status_e          status;
    logic [7:0]        id;
    logic signed [31:0] key;
    logic [31:0]       data;
  } heap_result_t;

  // predictor of the heap, slots numbered from 1
  class heap_scoreboard;
    logic signed [31:0] keys[CAP+1];
    logic [7:0] ids[CAP+1];
    logic [31:0] pays[CAP+1];
    int pos[IDS];
    bit present[IDS];
    int count;
    heap_result_t pending[$];
    int errors;

    function void swap_slots(int a, int b);
      logic signed [31:0] k;
      logic [7:0] i;
      logic [31:0] d;
      k = keys[a]; i = ids[a]; d = pays[a];
      keys[a] = keys[b]; ids[a] = ids[b]; pays[a] = pays[b];
      keys[b] = k; ids[b] = i; pays[b] = d;
      pos[ids[a]] = a;
      pos[ids[b]] = b;
    endfunction

    function void sift_up(int p);
      while (p > 1 && p <= count && keys[p] < keys[p/2]) begin
        swap_slots(p, p/2);
        p = p / 2;
      end
    endfunction

    function void sift_down(int p);
      int l, t;
      while (p >= 1 && 2*p <= count) begin
        l = 2*p;
        // equal keys take the right child
        if (l+1 > count || keys[l] < keys[l+1]) t = l;
        else t = l+1;
        if (!(keys[t] < keys[p])) break;
        swap_slots(p, t);
        p = t;
      end
    endfunction

    function void fill_from_last(int p);
      if (p != count) begin
        keys[p] = keys[count]; ids[p] = ids[count]; pays[p] = pays[count];
        pos[ids[p]] = p;
      end
      count--;
    endfunction

    function void note_word(cmd_e c, logic [7:0] id, logic signed [31:0] key,
                            logic [31:0] data);
      heap_result_t r;
      int p;
      bit last;
      logic signed [31:0] old;
      r = '{ST_OK, 8'd0, 32'sd0, 32'd0};
      case (c)
        CMD_INSERT: begin
          if (count >= CAP) r.status = ST_FULL;
          else if (present[id]) r.status = ST_DUP;
          else begin
            count++;
            keys[count] = key; ids[count] = id; pays[count] = data;
            pos[id] = count; present[id] = 1;
            sift_up(count);
          end
        end
        CMD_CHANGE: begin
          if (!present[id]) r.status = ST_NOTFOUND;
          else begin
            p = pos[id];
            old = keys[p];
            keys[p] = key;
            if (key < old) sift_up(p);
            else sift_down(p);
          end
        end
        CMD_DELMIN: begin
          if (count == 0) r.status = ST_EMPTY;
          else begin
            r.id = ids[1]; r.key = keys[1]; r.data = pays[1];
            present[ids[1]] = 0;
            fill_from_last(1);
            sift_down(1);
          end
        end
        default: begin
          if (!present[id]) r.status = ST_NOTFOUND;
          else begin
            p = pos[id];
            last = (p == count);
            r.key = keys[p]; r.data = pays[p];
            present[id] = 0;
            fill_from_last(p);
            if (!last) begin
              if (p > 1 && keys[p] < keys[p/2]) sift_up(p);
              else sift_down(p);
            end
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_word(logic [2:0] st, logic [7:0] id, logic signed [31:0] key,
                             logic [31:0] data);
      heap_result_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status expected %0d actual %0d", e.status, st); errors++;
      end
      if (id !== e.id) begin
        $error("out_id expected %0d actual %0d", e.id, id); errors++;
      end
      if (key !== e.key) begin
        $error("out_key expected %0d actual %0d", e.key, key); errors++;
      end
      if (data !== e.data) begin
        $error("out_data expected %h actual %h", e.data, data); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = '0;
  logic [7:0] item_id_i = '0;
  logic signed [31:0] item_key_i = '0;
  logic [31:0] item_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [7:0] out_id_o;
  logic signed [31:0] out_key_o;
  logic [31:0] out_data_o;

  heap_scoreboard sb = new();
  int gap_left = 0;
  int burst_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  indexed_min_heap_queue dut (.*);

  // sample on the edge, before the nonblocking updates land
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_word(cmd_e'(cmd_i), item_id_i, item_key_i, item_data_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(status_o, out_id_o, out_key_o, out_data_o);
  end

  // receiver stalls: quiet stretches alternate with random ones
  int stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (stall_phase < 80) out_ready_i <= 1'b1;
    else if (stall_phase < 200) out_ready_i <= ($urandom_range(0, 3) != 0);
    else out_ready_i <= ($urandom_range(0, 2) == 0);
  end

  // valid stays up between words of a burst and drops only for a gap
  task automatic send_word(cmd_e c, logic [7:0] id, logic signed [31:0] key,
                           logic [31:0] data);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
    end
    if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i <= c;
    item_id_i <= id;
    item_key_i <= key;
    item_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_key(int span);
    case ($urandom_range(0, 9))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return $urandom();
      default: return $signed($urandom_range(0, span)) - span / 2;
    endcase
  endfunction

  function automatic logic [7:0] pick_id(int span);
    return 8'($urandom_range(0, span));
  endfunction

  initial begin
    int span;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_word(CMD_DELMIN, 8'd0, 32'sd0, 32'd0);
    send_word(CMD_REMOVE, 8'd5, 32'sd0, 32'd0);
    send_word(CMD_CHANGE, 8'd255, 32'sd1, 32'd0);
    send_word(CMD_INSERT, 8'd0, 32'sh7fffffff, 32'hffffffff);
    send_word(CMD_INSERT, 8'd255, 32'sh80000000, 32'h00000000);
    send_word(CMD_INSERT, 8'd0, 32'sd3, 32'd1);
    send_word(CMD_INSERT, 8'd7, 32'sd5, 32'haaaaaaaa);
    send_word(CMD_INSERT, 8'd8, 32'sd5, 32'h55555555);
    send_word(CMD_INSERT, 8'd9, 32'sd5, 32'h12345678);
    send_word(CMD_CHANGE, 8'd0, 32'sh80000000, 32'd0);
    send_word(CMD_CHANGE, 8'd255, 32'sh7fffffff, 32'd0);
    send_word(CMD_REMOVE, 8'd8, 32'sd0, 32'd0);
    send_word(CMD_REMOVE, 8'd255, 32'sd0, 32'd0);
    send_word(CMD_DELMIN, 8'd0, 32'sd0, 32'd0);
    send_word(CMD_DELMIN, 8'd0, 32'sd0, 32'd0);
    send_word(CMD_DELMIN, 8'd0, 32'sd0, 32'd0);
    send_word(CMD_DELMIN, 8'd0, 32'sd0, 32'd0);
    wait_drained();

    // fill to capacity, then overflow with fresh and duplicate ids
    for (int i = 0; i < CAP; i++)
      send_word(CMD_INSERT, i[7:0], pick_key(64), $urandom());
    send_word(CMD_INSERT, 8'd200, 32'sd1, 32'd1);
    send_word(CMD_INSERT, 8'd3, 32'sd1, 32'd1);
    for (int i = 0; i < 60; i++)
      send_word(cmd_e'($urandom_range(1, 3)), pick_id(255), pick_key(64), $urandom());
    wait_drained();

    // random mix, phases with small id spaces to get hits and ties
    for (int i = 0; i < 750; i++) begin
      span = (i < 250) ? 15 : (i < 500) ? 63 : 255;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_word(CMD_INSERT, pick_id(span), pick_key(8), $urandom());
        4, 5: send_word(CMD_CHANGE, pick_id(span), pick_key(8), $urandom());
        6, 7: send_word(CMD_DELMIN, pick_id(255), pick_key(8), $urandom());
        default: send_word(CMD_REMOVE, pick_id(span), pick_key(8), $urandom());
      endcase
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("indexed_min_heap_queue verification clean");
    else
      $display("indexed_min_heap_queue verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("indexed_min_heap_queue verification failed");
    $finish;
  end

endmodule
